// ===== sv/cppt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Convex polygon point test: shared package
// Request codes, fixed field widths and the status groups passed between
// the front, the queue and the back of the block.
// ----------------------------------------------------------------------------
package cppt_pkg;

	localparam int COUNT_W = 5;
	localparam int INDEX_W = 4;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd3;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_TEST  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic idle;
		logic result_wait;
	} bk_stat_t;

endpackage

// ===== sv/cppt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Convex polygon point test: front end
// Registers each request, drops corner writes aimed outside the table and
// packs the rest into queue entries.
// ----------------------------------------------------------------------------
module cppt_front import cppt_pkg::*; #(
	parameter int MAX_CORNERS = 16,
	parameter int COORD_BITS  = 16,
	localparam int IDX_W      = $clog2(MAX_CORNERS),
	localparam int E_W        = 1 + IDX_W + 2 * COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic                         command,
	input  logic [INDEX_W-1:0]           corner_index,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	output logic                         q_push,
	output logic [E_W-1:0]               q_push_data,
	input  q_stat_t                      q_stat
);

	logic           valid_s1;
	logic           keep_s1;
	logic [E_W-1:0] entry_s1;
	logic           advance;
	logic           keep;
	logic [31:0]    idx_ext;

	assign idx_ext = 32'(corner_index);
	assign keep    = (command == CMD_TEST) || (idx_ext < 32'(MAX_CORNERS));

	assign advance     = valid_s1 && (!keep_s1 || !q_stat.full);
	assign req_ready   = !valid_s1 || advance;
	assign q_push      = valid_s1 && keep_s1 && !q_stat.full;
	assign q_push_data = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			keep_s1  <= keep;
			entry_s1 <= {command, idx_ext[IDX_W-1:0], coord_x, coord_y};
		end
	end

endmodule

// ===== sv/cppt_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Convex polygon point test: request queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module cppt_queue import cppt_pkg::*; #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output q_stat_t           stat
);

	logic [DATA_W-1:0] slot_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        fill_q;

	assign stat.full  = (fill_q == 2'd2);
	assign stat.empty = (fill_q == 2'd0);
	assign pop_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== sv/cppt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Convex polygon point test: back end
// Holds the corner memory and the count register, walks the edges of the
// polygon with one shared multiplier and drives the result register.
// ----------------------------------------------------------------------------
module cppt_back import cppt_pkg::*; #(
	parameter int MAX_CORNERS = 16,
	parameter int COORD_BITS  = 16,
	localparam int IDX_W      = $clog2(MAX_CORNERS),
	localparam int E_W        = 1 + IDX_W + 2 * COORD_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,
	input  logic [E_W-1:0]     q_data,
	input  q_stat_t            q_stat,
	output logic               q_pop,
	output bk_stat_t           stat,
	output logic               res_valid,
	input  logic               res_ready,
	output logic               inside_res
);

	localparam int CNT_W = $clog2(MAX_CORNERS + 1);
	localparam int C_W   = COORD_BITS;
	localparam int D_W   = COORD_BITS + 1;
	localparam int P_W   = 2 * D_W;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_FIRST = 6'b000010,
		S_DIFF  = 6'b000100,
		S_MUL1  = 6'b001000,
		S_MUL2  = 6'b010000,
		S_OUT   = 6'b100000
	} bk_state_t;

	bk_state_t               state_q;
	logic [COUNT_W-1:0]      count_q;
	logic [CNT_W-1:0]        n_eff;
	logic [2*C_W-1:0]        corner_mem_q [MAX_CORNERS];
	logic [2*C_W-1:0]        rd_q;
	logic                    rd_en;
	logic [IDX_W-1:0]        rd_addr;
	logic [IDX_W-1:0]        k_q;
	logic                    closing_q;
	logic                    verdict_q;
	logic                    res_valid_q;
	logic                    res_q;
	logic                    cmp_q;
	logic signed [C_W-1:0]   px_q, py_q;
	logic signed [C_W-1:0]   first_x_q, first_y_q;
	logic signed [C_W-1:0]   prev_x_q, prev_y_q;
	logic signed [C_W-1:0]   cur_x, cur_y;
	logic signed [D_W-1:0]   a1_q, b1_q, a2_q, b2_q;
	logic signed [D_W-1:0]   mul_a, mul_b;
	logic signed [P_W-1:0]   prod;
	logic signed [P_W-1:0]   p_q;
	cmd_t                    q_cmd;
	logic [IDX_W-1:0]        q_slot;
	logic [2*C_W-1:0]        q_xy;
	logic                    last_edge;
	logic                    out_free;

	assign q_cmd  = cmd_t'(q_data[E_W-1]);
	assign q_slot = q_data[E_W-2 -: IDX_W];
	assign q_xy   = q_data[2*C_W-1:0];

	assign n_eff = (32'(count_q) > 32'(MAX_CORNERS)) ? CNT_W'(MAX_CORNERS) : CNT_W'(count_q);

	assign q_pop = !q_stat.empty && (state_q == S_IDLE);

	assign stat.idle        = (state_q == S_IDLE);
	assign stat.result_wait = (state_q == S_OUT);

	assign cur_x = closing_q ? first_x_q : $signed(rd_q[2*C_W-1:C_W]);
	assign cur_y = closing_q ? first_y_q : $signed(rd_q[C_W-1:0]);

	assign mul_a = (state_q == S_MUL1) ? a1_q : a2_q;
	assign mul_b = (state_q == S_MUL1) ? b1_q : b2_q;
	assign prod  = P_W'(mul_a) * P_W'(mul_b);

	assign last_edge = ((CNT_W'(k_q) + CNT_W'(1)) == n_eff);
	assign out_free  = !res_valid_q || res_ready;

	assign res_valid  = res_valid_q;
	assign inside_res = res_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			S_IDLE: begin
				rd_en = q_pop && (q_cmd == CMD_TEST);
			end
			S_FIRST: begin
				rd_en   = (n_eff != CNT_W'(1));
				rd_addr = IDX_W'(1);
			end
			S_MUL2: begin
				rd_en   = !cmp_q && !closing_q && !last_edge;
				rd_addr = k_q + IDX_W'(1);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop && (q_cmd == CMD_WRITE)) begin
			corner_mem_q[q_slot] <= q_xy;
		end
		if (rd_en) begin
			rd_q <= corner_mem_q[rd_addr];
		end
	end

	// p < q means the point lies on the outer side of the edge
	assign cmp_q = (p_q < prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= COUNT_RESET;
			res_valid_q <= 1'b0;
			closing_q   <= 1'b0;
			k_q         <= '0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if ((state_q != S_OUT) && res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_pop && (q_cmd == CMD_TEST)) begin
						state_q <= (n_eff == '0) ? S_OUT : S_FIRST;
					end
				end
				S_FIRST: begin
					closing_q <= (n_eff == CNT_W'(1));
					k_q       <= IDX_W'(1);
					state_q   <= S_DIFF;
				end
				S_DIFF: begin
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					if (cmp_q || closing_q) begin
						state_q <= S_OUT;
					end else if (last_edge) begin
						closing_q <= 1'b1;
						state_q   <= S_DIFF;
					end else begin
						k_q     <= k_q + IDX_W'(1);
						state_q <= S_DIFF;
					end
				end
				S_OUT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						closing_q   <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				px_q      <= $signed(q_xy[2*C_W-1:C_W]);
				py_q      <= $signed(q_xy[C_W-1:0]);
				verdict_q <= 1'b1;
			end
			S_FIRST: begin
				first_x_q <= $signed(rd_q[2*C_W-1:C_W]);
				first_y_q <= $signed(rd_q[C_W-1:0]);
				prev_x_q  <= $signed(rd_q[2*C_W-1:C_W]);
				prev_y_q  <= $signed(rd_q[C_W-1:0]);
			end
			S_DIFF: begin
				a1_q     <= D_W'(px_q) - D_W'(prev_x_q);
				b1_q     <= D_W'(cur_y) - D_W'(prev_y_q);
				a2_q     <= D_W'(py_q) - D_W'(prev_y_q);
				b2_q     <= D_W'(cur_x) - D_W'(prev_x_q);
				prev_x_q <= cur_x;
				prev_y_q <= cur_y;
			end
			S_MUL1: begin
				p_q <= prod;
			end
			S_MUL2: begin
				if (cmp_q) begin
					verdict_q <= 1'b0;
				end
			end
			S_OUT: begin
				if (out_free) begin
					res_q <= verdict_q;
				end
			end
			default: begin
				verdict_q <= verdict_q;
			end
		endcase
	end

endmodule

// ===== sv/convex_polygon_point_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Convex polygon point test: top level
// Geofence check of a point against a clockwise convex polygon whose corners
// are loaded by write requests. Corner writes give no result; a test request
// gives one bit, set when the point is inside or on the boundary.
// ----------------------------------------------------------------------------
// A corner write is registered in the front, pushed into the queue and stored
// by the back when it pops the entry. A point test walks the edges in the
// back, one per corner, the corner count being limited to the table size:
// each edge costs a difference step and two passes through the single signed
// multiplier, whose second product is compared against the first, and the
// corner memory gives one corner per read; the test stops at the first edge
// that the point lies outside. A request queue of two entries lets the front
// keep taking requests while a test runs, and the result register lets the
// back start the next request while a result waits to be taken.
module convex_polygon_point_test import cppt_pkg::*; #(
	parameter int MAX_CORNERS = 16,
	parameter int COORD_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [COUNT_W-1:0]           cfg_wdata,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic                         command,
	input  logic [INDEX_W-1:0]           corner_index,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic                         inside_res
);

	localparam int IDX_W = $clog2(MAX_CORNERS);
	localparam int E_W   = 1 + IDX_W + 2 * COORD_BITS;

	logic           q_push;
	logic           q_pop;
	logic [E_W-1:0] q_push_data;
	logic [E_W-1:0] q_pop_data;
	q_stat_t        q_stat;
	bk_stat_t       bk_stat;

	cppt_front #(
		.MAX_CORNERS (MAX_CORNERS),
		.COORD_BITS  (COORD_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.command      (command),
		.corner_index (corner_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.q_push       (q_push),
		.q_push_data  (q_push_data),
		.q_stat       (q_stat)
	);

	cppt_queue #(
		.DATA_W (E_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.stat      (q_stat)
	);

	cppt_back #(
		.MAX_CORNERS (MAX_CORNERS),
		.COORD_BITS  (COORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.q_data     (q_pop_data),
		.q_stat     (q_stat),
		.q_pop      (q_pop),
		.stat       (bk_stat),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.inside_res (inside_res)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !q_push)
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty |-> !q_pop)
		else $error("pop from empty queue");

	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> bk_stat.idle)
		else $error("pop while back is busy");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(bk_stat.result_wait))
		else $error("result without a finished test");

endmodule
